// ===== rtl/bdq_pkg.sv =====
package bdq_pkg;

  localparam int unsigned OPCODE_W = 3;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned STATUS_W = 2;

  localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_PUSH_BACK  = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_DUMP       = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_POP_FRONT  = 3'd4;
  localparam logic [OPCODE_W-1:0] OP_POP_BACK   = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STATUS_W-1:0] ST_ENTRY = 2'd3;

  localparam logic [1:0] SEL_HOLD = 2'd0;
  localparam logic [1:0] SEL_PREV = 2'd1;
  localparam logic [1:0] SEL_NEXT = 2'd2;
  localparam logic [1:0] SEL_LOAD = 2'd3;

  typedef logic signed [WORD_W-1:0] word_t;

  typedef struct packed {
    logic [1:0] sel;
  } cell_ctrl_t;

endpackage

// ===== rtl/bounded_double_ended_queue.sv =====
// Push, pop and empty dump: result registered in the cycle after start, a new word every cycle.
// Dump: all entries from front to back, one entry per cycle, each registered from
// the head cell once the dumping flag is set; busy is high while the cells
// rotate, so the next word is taken only after busy drops with the last entry.
// Results come with strobe for one cycle; the receiver cannot stall.
// Synchronous reset empties the queue; cell contents are not cleared.
module bounded_double_ended_queue #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [bdq_pkg::OPCODE_W-1:0] opcode,
  input  bdq_pkg::word_t               value,
  output logic                         strobe,
  output bdq_pkg::word_t               item,
  output logic [bdq_pkg::STATUS_W-1:0] status,
  output logic                         last
);
  import bdq_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [CW-1:0] count, count_next;
  logic [CW-1:0] remain, remain_next;
  logic          dumping, dumping_next;
  logic          accept;
  logic          is_full, is_empty;

  word_t      cdata [DEPTH];
  cell_ctrl_t ctrl  [DEPTH];
  word_t      load_bus;

  assign accept   = start && !busy;
  assign busy     = dumping;
  assign is_full  = (count == CW'(DEPTH));
  assign is_empty = (count == '0);
  assign load_bus = dumping ? cdata[0] : value;

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      word_t prev_d, next_d;
      if (gi == 0) begin : g_head
        assign prev_d = '0;
      end else begin : g_mid_p
        assign prev_d = cdata[gi-1];
      end
      if (gi == DEPTH - 1) begin : g_tail
        assign next_d = '0;
      end else begin : g_mid_n
        assign next_d = cdata[gi+1];
      end

      always_comb begin
        ctrl[gi].sel = SEL_HOLD;
        if (dumping) begin
          if (CW'(gi) == count - CW'(1)) begin
            ctrl[gi].sel = SEL_LOAD;
          end else if (CW'(gi) < count) begin
            ctrl[gi].sel = SEL_NEXT;
          end
        end else if (accept) begin
          case (opcode)
            OP_PUSH_FRONT: begin
              if (!is_full) begin
                ctrl[gi].sel = (gi == 0) ? SEL_LOAD : SEL_PREV;
              end
            end
            OP_PUSH_BACK: begin
              if (!is_full && count == CW'(gi)) begin
                ctrl[gi].sel = SEL_LOAD;
              end
            end
            OP_POP_FRONT: begin
              if (!is_empty) begin
                ctrl[gi].sel = SEL_NEXT;
              end
            end
            default: ctrl[gi].sel = SEL_HOLD;
          endcase
        end
      end

      bdq_cell u_cell (
        .clk       (clk),
        .ctrl      (ctrl[gi]),
        .prev_data (prev_d),
        .next_data (next_d),
        .load_data (load_bus),
        .data      (cdata[gi])
      );
    end
  endgenerate

  word_t               item_next;
  logic [STATUS_W-1:0] status_next;
  logic                last_next, strobe_next;

  always_comb begin
    count_next   = count;
    remain_next  = remain;
    dumping_next = dumping;
    strobe_next  = 1'b0;
    item_next    = '0;
    status_next  = ST_OK;
    last_next    = 1'b0;
    if (dumping) begin
      strobe_next = 1'b1;
      item_next   = cdata[0];
      status_next = ST_ENTRY;
      last_next   = (remain == CW'(1));
      remain_next = remain - CW'(1);
      if (remain == CW'(1)) begin
        dumping_next = 1'b0;
      end
    end else if (accept) begin
      case (opcode)
        OP_PUSH_FRONT, OP_PUSH_BACK: begin
          strobe_next = 1'b1;
          last_next   = 1'b1;
          if (is_full) begin
            status_next = ST_FULL;
          end else begin
            count_next = count + CW'(1);
          end
        end
        OP_POP_FRONT, OP_POP_BACK: begin
          strobe_next = 1'b1;
          last_next   = 1'b1;
          if (is_empty) begin
            status_next = ST_EMPTY;
          end else begin
            count_next = count - CW'(1);
          end
        end
        OP_DUMP: begin
          if (is_empty) begin
            strobe_next = 1'b1;
            last_next   = 1'b1;
            status_next = ST_EMPTY;
          end else begin
            dumping_next = 1'b1;
            remain_next  = count;
          end
        end
        default: strobe_next = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      remain  <= '0;
      dumping <= 1'b0;
      strobe  <= 1'b0;
    end else begin
      count   <= count_next;
      remain  <= remain_next;
      dumping <= dumping_next;
      strobe  <= strobe_next;
    end
    item   <= item_next;
    status <= status_next;
    last   <= last_next;
  end

endmodule

// ===== rtl/bdq_cell.sv =====
module bdq_cell (
  input  logic               clk,
  input  bdq_pkg::cell_ctrl_t ctrl,
  input  bdq_pkg::word_t     prev_data,
  input  bdq_pkg::word_t     next_data,
  input  bdq_pkg::word_t     load_data,
  output bdq_pkg::word_t     data
);
  import bdq_pkg::*;

  word_t data_next;

  always_comb begin
    case (ctrl.sel)
      SEL_HOLD: data_next = data;
      SEL_PREV: data_next = prev_data;
      SEL_NEXT: data_next = next_data;
      SEL_LOAD: data_next = load_data;
      default:  data_next = data;
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

// ===== tb/tb_bounded_double_ended_queue.sv =====
`timescale 1ns / 1ps

module tb_bounded_double_ended_queue;
  import bdq_pkg::*;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned WORDS_TARGET = 360;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned TAIL_CYCLES = 40;

  // opcodes the block ignores
  localparam logic [OPCODE_W-1:0] OP_RSVD0 = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_RSVD6 = 3'd6;
  localparam logic [OPCODE_W-1:0] OP_RSVD7 = 3'd7;

  typedef struct packed {
    word_t               item;
    logic [STATUS_W-1:0] status;
    logic                last;
  } deque_out_t;

  typedef struct packed {
    logic [OPCODE_W-1:0] op;
    word_t               val;
    logic                typed;
    logic [STATUS_W-1:0] st;
  } stim_row_t;

  localparam int unsigned N_DIRECTED = 21;
  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    '{OP_POP_FRONT,  32'sh0000_0000, 1'b1, ST_EMPTY},
    '{OP_POP_BACK,   32'sh0000_0000, 1'b1, ST_EMPTY},
    '{OP_DUMP,       32'sh0000_0000, 1'b1, ST_EMPTY},
    '{OP_RSVD0,      32'sh0000_1234, 1'b0, ST_OK},
    '{OP_RSVD6,      32'shFFFF_FFFF, 1'b0, ST_OK},
    '{OP_RSVD7,      32'sh8000_0000, 1'b0, ST_OK},
    '{OP_PUSH_BACK,  32'sh7FFF_FFFF, 1'b1, ST_OK},
    '{OP_PUSH_FRONT, 32'sh8000_0000, 1'b1, ST_OK},
    '{OP_PUSH_BACK,  32'sh0000_0000, 1'b1, ST_OK},
    '{OP_PUSH_FRONT, 32'shFFFF_FFFF, 1'b1, ST_OK},
    '{OP_DUMP,       32'sh0000_0000, 1'b0, ST_OK},
    '{OP_POP_FRONT,  32'sh0000_0000, 1'b1, ST_OK},
    '{OP_POP_BACK,   32'sh0000_0000, 1'b1, ST_OK},
    '{OP_DUMP,       32'sh0000_0000, 1'b0, ST_OK},
    '{OP_POP_BACK,   32'sh0000_0000, 1'b1, ST_OK},
    '{OP_POP_FRONT,  32'sh0000_0000, 1'b1, ST_OK},
    '{OP_POP_FRONT,  32'sh0000_0000, 1'b1, ST_EMPTY},
    '{OP_DUMP,       32'sh0000_0000, 1'b1, ST_EMPTY},
    '{OP_PUSH_FRONT, 32'sh5A5A_5A5A, 1'b1, ST_OK},
    '{OP_DUMP,       32'sh0000_0000, 1'b0, ST_OK},
    '{OP_POP_BACK,   32'sh0000_0000, 1'b1, ST_OK}
  };

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic [OPCODE_W-1:0] opcode = OP_RSVD0;
  word_t               value = '0;
  logic                busy;
  logic                strobe;
  word_t               item;
  logic [STATUS_W-1:0] status;
  logic                last;

  // typed expectation travels with the word
  logic                chk_typed = 1'b0;
  logic [STATUS_W-1:0] chk_status = ST_OK;

  word_t       ring_words [DEPTH];
  int unsigned ring_front = 0;
  int unsigned ring_count = 0;
  deque_out_t  pending_outputs [$];

  int unsigned mismatches = 0;
  int unsigned words_sent = 0;
  int unsigned quiet_cycles = 0;
  bit          no_idle = 1'b0;
  deque_out_t  got_out;
  deque_out_t  typed_out;

  bounded_double_ended_queue #(.DEPTH(DEPTH)) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .opcode(opcode),
    .value(value),
    .strobe(strobe),
    .item(item),
    .status(status),
    .last(last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic deque_apply(input logic [OPCODE_W-1:0] op, input word_t val);
    deque_out_t r;
    int unsigned k;
    r.item = '0;
    r.status = ST_OK;
    r.last = 1'b1;
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (ring_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          if (op == OP_PUSH_FRONT) begin
            ring_front = (ring_front + DEPTH - 1) % DEPTH;
            ring_words[ring_front] = val;
          end else begin
            ring_words[(ring_front + ring_count) % DEPTH] = val;
          end
          ring_count++;
        end
        pending_outputs.push_back(r);
      end
      OP_DUMP: begin
        if (ring_count == 0) begin
          r.status = ST_EMPTY;
          pending_outputs.push_back(r);
        end else begin
          for (k = 0; k < ring_count; k++) begin
            r.item = ring_words[(ring_front + k) % DEPTH];
            r.status = ST_ENTRY;
            r.last = (k + 1 == ring_count);
            pending_outputs.push_back(r);
          end
        end
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (ring_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          if (op == OP_POP_FRONT) ring_front = (ring_front + 1) % DEPTH;
          ring_count--;
        end
        pending_outputs.push_back(r);
      end
      default: ;
    endcase
  endtask

  task automatic flag_mismatch(input string what, input deque_out_t want,
                               input deque_out_t got);
    mismatches++;
    if (mismatches <= 10)
      $display({"mismatch, %s: expected item %0d status %0d last %0b, ",
                "got item %0d status %0d last %0b"},
               what, want.item, want.status, want.last, got.item, got.status, got.last);
  endtask

  // results are checked before the word accepted at the same edge is predicted
  always @(posedge clk) begin
    if (!rst) begin
      if (strobe) begin
        got_out = '{item: item, status: status, last: last};
        if (pending_outputs.size() == 0) begin
          flag_mismatch("unexpected result", '0, got_out);
        end else if (item !== pending_outputs[0].item ||
                     status !== pending_outputs[0].status ||
                     last !== pending_outputs[0].last) begin
          flag_mismatch("wrong field", pending_outputs.pop_front(), got_out);
        end else begin
          void'(pending_outputs.pop_front());
        end
      end
      if (start && !busy) begin
        deque_apply(opcode, value);
        if (chk_typed) begin
          void'(pending_outputs.pop_back());
          typed_out = '{item: '0, status: chk_status, last: 1'b1};
          pending_outputs.push_back(typed_out);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_word(input logic [OPCODE_W-1:0] op, input word_t val,
                           input logic typed, input logic [STATUS_W-1:0] st);
    if (!no_idle && $urandom_range(99) < 7) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start <= 1'b1;
    opcode <= op;
    value <= val;
    chk_typed <= typed;
    chk_status <= st;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (op >= OP_PUSH_FRONT && op <= OP_POP_BACK) words_sent++;
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending_outputs.size() != 0) @(posedge clk);
  endtask

  function automatic word_t pick_word();
    case ($urandom_range(15))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return 32'sh0000_0000;
      3: return 32'shFFFF_FFFF;
      default: return word_t'($urandom);
    endcase
  endfunction

  function automatic logic [OPCODE_W-1:0] pick_rsvd();
    case ($urandom_range(2))
      0: return OP_RSVD0;
      1: return OP_RSVD6;
      default: return OP_RSVD7;
    endcase
  endfunction

  function automatic logic [OPCODE_W-1:0] pick_op();
    case ($urandom_range(4))
      0: return OP_PUSH_FRONT;
      1: return OP_PUSH_BACK;
      2: return OP_DUMP;
      3: return OP_POP_FRONT;
      default: return OP_POP_BACK;
    endcase
  endfunction

  initial begin
    int unsigned i;
    int unsigned n;
    int unsigned pick;
    bit paused;
    paused = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < N_DIRECTED; i++)
      send_word(DIRECTED[i].op, DIRECTED[i].val, DIRECTED[i].typed, DIRECTED[i].st);

    pick = 0;
    while (words_sent < WORDS_TARGET) begin
      no_idle = (words_sent >= 200 && words_sent < 300);
      if (!paused && words_sent >= 180) begin
        drain_results();
        paused = 1'b1;
      end
      case (pick)
        0, 1, 2: begin
          // fill past full, then read it all back
          n = DEPTH + $urandom_range(1, 3);
          for (i = 0; i < n; i++)
            send_word($urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK, pick_word(),
                      1'b0, ST_OK);
          send_word(OP_DUMP, pick_word(), 1'b0, ST_OK);
        end
        3, 4: begin
          // drain past empty
          n = DEPTH + $urandom_range(1, 2);
          for (i = 0; i < n; i++)
            send_word($urandom_range(1) ? OP_POP_FRONT : OP_POP_BACK, pick_word(),
                      1'b0, ST_OK);
          send_word(OP_DUMP, pick_word(), 1'b0, ST_OK);
        end
        5, 6, 7, 8: begin
          n = $urandom_range(4, 12);
          for (i = 0; i < n; i++)
            send_word(pick_op(), pick_word(), 1'b0, ST_OK);
        end
        default: begin
          send_word(pick_rsvd(), pick_word(), 1'b0, ST_OK);
        end
      endcase
      pick = $urandom_range(9);
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_outputs.size() != 0) begin
      mismatches += pending_outputs.size();
      $display("%0d expected results never arrived", pending_outputs.size());
    end
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
